FILE: src/ussb_pkg.sv
// Shared types, constants and fixed-point helpers for the sector scan builder.
// No dependencies; imported by ussb_store and the top level.
package ussb_pkg;

  localparam int NUM_BINS_DEF    = 720;
  localparam int NUM_SENSORS_DEF = 12;

  localparam int DATA_W = 16;
  localparam int SECT_W = 12;
  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CW     = 28;
  localparam int ZW     = 26;
  localparam int DEG_W  = 11;

  localparam logic [DATA_W-1:0] NO_ECHO = 16'hFFFF;

  // floor(v / 100) == (v * RECIP) >> RECIP_SH for v < 2^20
  localparam logic signed [MUL_W-1:0] RECIP    = 24'sd1342178;
  localparam int                      RECIP_SH = 27;
  localparam logic signed [MUL_W-1:0] TAN_HB   = 24'sd11924;
  localparam logic signed [ZW-1:0]    DEG180   = 26'sd11796480;

  typedef enum logic [1:0] {
    OP_APPLY = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_MIN_RANGE = 2'd0,
    CFG_MAX_RANGE = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } pose_t;

  function automatic pose_t mount_pose(input logic [3:0] idx);
    pose_t p;
    p = '{dx: 16'sd0, dy: 16'sd0, cs: 16'sd32767, sn: 16'sd0};
    unique case (idx)
      4'd0:  p = '{dx:  16'sd1032, dy:   16'sd934, cs:  16'sd24198, sn:  16'sd22095};
      4'd1:  p = '{dx:  16'sd1083, dy:   16'sd573, cs:  16'sd32767, sn:      16'sd0};
      4'd2:  p = '{dx:  16'sd1083, dy:  -16'sd573, cs:  16'sd32767, sn:      16'sd0};
      4'd3:  p = '{dx:  16'sd1028, dy:  -16'sd934, cs:  16'sd24198, sn: -16'sd22095};
      4'd4:  p = '{dx:   16'sd553, dy: -16'sd1026, cs:   16'sd2971, sn: -16'sd32633};
      4'd5:  p = '{dx:  -16'sd553, dy: -16'sd1122, cs:   16'sd2971, sn: -16'sd32633};
      4'd6:  p = '{dx: -16'sd1016, dy: -16'sd1104, cs: -16'sd22114, sn: -16'sd24181};
      4'd7:  p = '{dx: -16'sd1083, dy:  -16'sd573, cs: -16'sd32768, sn:     16'sd52};
      4'd8:  p = '{dx: -16'sd1083, dy:   16'sd573, cs: -16'sd32768, sn:     16'sd52};
      4'd9:  p = '{dx: -16'sd1016, dy:  16'sd1104, cs: -16'sd22114, sn:  16'sd24181};
      4'd10: p = '{dx:  -16'sd635, dy:  16'sd1122, cs:   16'sd2971, sn:  16'sd32633};
      4'd11: p = '{dx:   16'sd553, dy:  16'sd1026, cs:   16'sd2971, sn:  16'sd32633};
      default: p = '{dx: 16'sd0, dy: 16'sd0, cs: 16'sd32767, sn: 16'sd0};
    endcase
    return p;
  endfunction

  function automatic logic signed [ZW-1:0] atan_deg(input logic [3:0] i);
    logic signed [ZW-1:0] a;
    unique case (i)
      4'd0:  a = 26'sd2949120;
      4'd1:  a = 26'sd1740967;
      4'd2:  a = 26'sd919879;
      4'd3:  a = 26'sd466945;
      4'd4:  a = 26'sd234379;
      4'd5:  a = 26'sd117304;
      4'd6:  a = 26'sd58666;
      4'd7:  a = 26'sd29335;
      4'd8:  a = 26'sd14668;
      4'd9:  a = 26'sd7334;
      4'd10: a = 26'sd3667;
      4'd11: a = 26'sd1833;
      4'd12: a = 26'sd917;
      4'd13: a = 26'sd458;
      4'd14: a = 26'sd229;
      default: a = 26'sd115;
    endcase
    return a;
  endfunction

  // shift right by 15, rounding half away from zero
  function automatic logic signed [PROD_W-1:0] rshift15(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] r;
    if (v >= 0) begin
      r = (v + 48'sd16384) >>> 15;
    end else begin
      r = -((-v + 48'sd16384) >>> 15);
    end
    return r;
  endfunction

  // Q16 degrees to whole degrees, truncated toward zero
  function automatic logic signed [DEG_W-1:0] trunc_deg(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] m;
    logic signed [DEG_W-1:0] r;
    if (z >= 0) begin
      m = z >>> 16;
      r = m[DEG_W-1:0];
    end else begin
      m = (-z) >>> 16;
      r = -m[DEG_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/ussb_store.sv
// Scan bin store: one write port, one read port with registered data.
// Depends on ussb_pkg.
module ussb_store
  import ussb_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF,
  parameter int AW       = $clog2(NUM_BINS)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [NUM_BINS];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ultrasonic_sector_scan_builder_top.sv
// Sector scan builder: one shared multiplier, shift-add CORDIC and sqrt under a sequencer.
// Depends on ussb_pkg and ussb_store. in_ready_o is low from an input transfer until its
// result reaches out_valid_o; an applied reading first runs the multiplier states, the sqrt,
// two CORDIC passes and its bin writes, and a result still held at the output adds its wait.
// One item at a time. After reset the store is swept to no-echo before the first transfer;
// config writes are taken anytime.
module ultrasonic_sector_scan_builder_top
  import ussb_pkg::*;
#(
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  sensor_index_i,
  input  logic [7:0]  range_cm_i,
  input  logic [9:0]  bin_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] bin_distance_o,
  output logic [9:0]  sector_start_o,
  output logic [9:0]  sector_end_o,
  output logic        accepted_o
);

  localparam int AW = $clog2(NUM_BINS);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_CLR, S_RD, S_RDW, S_X, S_C, S_S, S_T, S_Q1, S_Q2, S_Q3,
    S_SQRT, S_CPRE, S_CIT, S_SECT, S_FILL, S_DONE
  } state_e;

  state_e             state_q;
  logic               out_valid_q, clr_rep_q, pass_q;
  logic [7:0]         min_q, max_q;
  logic [SECT_W-1:0]  ptr_q;

  logic [1:0]         op_q;
  logic [3:0]         sidx_q;
  logic [7:0]         range_q;
  logic [9:0]         bidx_q;
  pose_t              pose;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q, prod_rs;
  logic signed [15:0]       x_q, xp_q, yp_q, xt_q, x_new;
  logic [31:0]              sq_v_q, sq_res_q, sq_bit_q, sq_sum;
  logic [DATA_W-1:0]        d_q;
  logic signed [CW-1:0]     cx_q, cy_q, sx, sy, shx, shy;
  logic signed [ZW-1:0]     cz_q;
  logic [4:0]               cit_q;
  logic signed [DEG_W-1:0]  centre_q, half_q, z_deg;
  logic signed [SECT_W-1:0] cen_s, sst_s, sen_s;
  logic [SECT_W-1:0]        end_q;

  logic [DATA_W-1:0]  res_dist_q, out_dist_q;
  logic [9:0]         res_start_q, res_end_q, out_start_q, out_end_q;
  logic               res_acc_q, out_acc_q;

  logic               store_we, store_re;
  logic [AW-1:0]      store_waddr;
  logic [DATA_W-1:0]  store_wdata, store_rdata;

  logic range_ok, sidx_ok, bidx_ok, fill_go, cord_done;

  assign pose       = mount_pose(sidx_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign sidx_ok  = {1'b0, sidx_q} < 5'(NUM_SENSORS);
  assign range_ok = (range_q >= min_q) && (range_q < max_q);
  assign bidx_ok  = {2'b00, bidx_q} < SECT_W'(NUM_BINS);
  assign fill_go  = (ptr_q < end_q) && (ptr_q < SECT_W'(NUM_BINS));
  assign cord_done = (cy_q == '0) || cit_q[4];

  assign prod_rs = rshift15(prod_q);
  assign x_new   = {1'b0, prod_q[RECIP_SH+14:RECIP_SH]};
  assign sq_sum  = sq_res_q + sq_bit_q;
  assign sx      = cx_q <<< 8;
  assign sy      = cy_q <<< 8;
  assign shx     = cx_q >>> cit_q[3:0];
  assign shy     = cy_q >>> cit_q[3:0];
  assign z_deg   = trunc_deg(cz_q);

  always_comb begin
    cen_s = (centre_q < 0) ? (SECT_W'(centre_q) + 12'sd360) : SECT_W'(centre_q);
    sst_s = (cen_s - SECT_W'(half_q)) <<< 1;
    if (sst_s < 0) begin
      sst_s = '0;
    end
    sen_s = (cen_s + SECT_W'(half_q)) <<< 1;
    if (sen_s > $signed(SECT_W'(NUM_BINS))) begin
      sen_s = $signed(SECT_W'(NUM_BINS - 1));
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_X: begin
        mul_a = $signed({4'b0, range_q, 12'd0}) + 24'sd50;
        mul_b = RECIP;
      end
      S_C: begin
        mul_a = MUL_W'(x_new);
        mul_b = MUL_W'(pose.cs);
      end
      S_S: begin
        mul_a = MUL_W'(x_q);
        mul_b = MUL_W'(pose.sn);
      end
      S_T: begin
        mul_a = MUL_W'(x_q);
        mul_b = TAN_HB;
      end
      S_Q1: begin
        mul_a = MUL_W'(xp_q);
        mul_b = MUL_W'(xp_q);
      end
      S_Q2: begin
        mul_a = MUL_W'(yp_q);
        mul_b = MUL_W'(yp_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    store_we    = 1'b0;
    store_waddr = ptr_q[AW-1:0];
    store_wdata = d_q;
    if (state_q == S_CLR) begin
      store_we    = 1'b1;
      store_wdata = NO_ECHO;
    end else if (state_q == S_FILL && fill_go) begin
      store_we = 1'b1;
    end
  end

  assign store_re = (state_q == S_RD);

  ussb_store #(
    .NUM_BINS (NUM_BINS),
    .AW       (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (store_wdata),
    .re_i    (store_re),
    .raddr_i (bidx_q[AW-1:0]),
    .rdata_o (store_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
      clr_rep_q   <= 1'b0;
      pass_q      <= 1'b0;
      ptr_q       <= '0;
      min_q       <= 8'd5;
      max_q       <= 8'd100;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MIN_RANGE: min_q <= cfg_data_i;
          CFG_MAX_RANGE: max_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          state_q <= S_DEC;
        end
        S_DEC: begin
          unique case (op_q)
            OP_APPLY: state_q <= (sidx_ok && range_ok) ? S_X : S_DONE;
            OP_READ:  state_q <= bidx_ok ? S_RD : S_DONE;
            OP_CLEAR: begin
              ptr_q     <= '0;
              clr_rep_q <= 1'b1;
              state_q   <= S_CLR;
            end
            default:  state_q <= S_DONE;
          endcase
        end
        S_CLR: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == SECT_W'(NUM_BINS - 1)) begin
            state_q <= clr_rep_q ? S_DONE : S_IDLE;
          end
        end
        S_RD:   state_q <= S_RDW;
        S_RDW:  state_q <= S_DONE;
        S_X:    state_q <= S_C;
        S_C:    state_q <= S_S;
        S_S:    state_q <= S_T;
        S_T:    state_q <= S_Q1;
        S_Q1:   state_q <= S_Q2;
        S_Q2:   state_q <= S_Q3;
        S_Q3:   state_q <= S_SQRT;
        S_SQRT: if (sq_bit_q == '0) begin
          pass_q  <= 1'b0;
          state_q <= S_CPRE;
        end
        S_CPRE: state_q <= S_CIT;
        S_CIT: if (cord_done) begin
          pass_q  <= 1'b1;
          state_q <= pass_q ? S_SECT : S_CPRE;
        end
        S_SECT: begin
          ptr_q   <= SECT_W'(sst_s);
          state_q <= S_FILL;
        end
        S_FILL: begin
          if (fill_go) begin
            ptr_q <= ptr_q + 1'b1;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: if (!out_valid_q || out_ready_i) begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: begin
        op_q    <= operation_i;
        sidx_q  <= sensor_index_i;
        range_q <= range_cm_i;
        bidx_q  <= bin_index_i;
      end
      S_DEC: begin
        res_dist_q  <= NO_ECHO;
        res_start_q <= '0;
        res_end_q   <= '0;
        res_acc_q   <= 1'b0;
      end
      S_RDW: res_dist_q <= store_rdata;
      S_C:   x_q  <= x_new;
      S_S:   xp_q <= prod_rs[15:0] + pose.dx;
      S_T:   yp_q <= prod_rs[15:0] + pose.dy;
      S_Q1:  xt_q <= prod_rs[15:0];
      S_Q2:  sq_v_q <= prod_q[31:0];
      S_Q3: begin
        sq_v_q   <= sq_v_q + prod_q[31:0];
        sq_res_q <= '0;
        sq_bit_q <= 32'h4000_0000;
      end
      S_SQRT: begin
        if (sq_bit_q == '0) begin
          d_q  <= sq_res_q[DATA_W-1:0];
          cx_q <= CW'(xp_q);
          cy_q <= CW'(yp_q);
        end else begin
          if (sq_v_q >= sq_sum) begin
            sq_v_q   <= sq_v_q - sq_sum;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
        end
      end
      S_CPRE: begin
        cit_q <= '0;
        if (sx < 0) begin
          cz_q <= (sy >= 0) ? DEG180 : -DEG180;
          cx_q <= -sx;
          cy_q <= -sy;
        end else begin
          cz_q <= '0;
          cx_q <= sx;
          cy_q <= sy;
        end
      end
      S_CIT: begin
        if (cord_done) begin
          if (!pass_q) begin
            centre_q <= z_deg;
            cx_q     <= CW'({1'b0, d_q});
            cy_q     <= CW'(xt_q);
          end else begin
            half_q <= z_deg;
          end
        end else begin
          cit_q <= cit_q + 1'b1;
          if (cy_q > 0) begin
            cx_q <= cx_q + shy;
            cy_q <= cy_q - shx;
            cz_q <= cz_q + atan_deg(cit_q[3:0]);
          end else begin
            cx_q <= cx_q - shy;
            cy_q <= cy_q + shx;
            cz_q <= cz_q - atan_deg(cit_q[3:0]);
          end
        end
      end
      S_SECT: begin
        end_q       <= SECT_W'(sen_s);
        res_dist_q  <= d_q;
        res_start_q <= sst_s[9:0];
        res_end_q   <= sen_s[9:0];
        res_acc_q   <= 1'b1;
      end
      S_DONE: if (!out_valid_q || out_ready_i) begin
        out_dist_q  <= res_dist_q;
        out_start_q <= res_start_q;
        out_end_q   <= res_end_q;
        out_acc_q   <= res_acc_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign bin_distance_o = out_dist_q;
  assign sector_start_o = out_start_q;
  assign sector_end_o   = out_end_q;
  assign accepted_o     = out_acc_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready held after a transfer");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> ptr_q < SECT_W'(NUM_BINS))
    else $error("store write beyond last bin");

  a_reject_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> sector_start_o == '0 && sector_end_o == '0)
    else $error("sector reported without accepted reading");

  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQRT |-> $onehot0(sq_bit_q))
    else $error("sqrt bit not one-hot");
`endif

endmodule
